// ----- src/gf2m_multiplier_macros.svh -----
// assertion macros used by the gf2m multiplier rtl
// each macro expects clk and rst_n in scope
`ifndef GF2M_MULTIPLIER_MACROS_SVH
`define GF2M_MULTIPLIER_MACROS_SVH

// same-cycle implication, checked outside reset
`define GF2M_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GF2M_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/gf2m_pkg.sv -----
// ----------------------------------------------------------------------------
// gf2m_pkg
// Shared widths, register indexes, types and the degree decode function for
// the GF(2^m) polynomial basis multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gf2m_pkg;

  // operand, polynomial and product width
  localparam int DATA_W = 32;
  // largest field degree supported by the design
  localparam int MAX_DEGREE = 32;
  localparam int EFF_MAX_DEGREE = (MAX_DEGREE > DATA_W) ? DATA_W : MAX_DEGREE;
  // one cell per operand bit, most significant bit first
  localparam int NUM_CELLS = DATA_W;

  // configuration port
  localparam int DEG_W = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_DEGREE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_LOW = 1'd1;

  // reset values
  localparam logic [DEG_W-1:0] RESET_DEGREE = 6'd8;
  localparam logic [DATA_W-1:0] RESET_POLY = 32'd27;

  // masks derived from the field degree
  typedef struct packed {
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] topbit;
  } deg_masks_t;

  // field settings seen by every cell
  typedef struct packed {
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] topbit;
    logic [DATA_W-1:0] poly;
  } field_cfg_t;

  // payload handed from cell to cell
  typedef struct packed {
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } stage_t;

  // clamp the degree and build the element mask and the top coefficient bit
  function automatic deg_masks_t deg_masks(input logic [DEG_W-1:0] deg);
    logic [DEG_W-1:0] m;
    deg_masks_t       res;
    m = deg;
    if (m < DEG_W'(2)) begin
      m = DEG_W'(2);
    end
    if (m > DEG_W'(EFF_MAX_DEGREE)) begin
      m = DEG_W'(EFF_MAX_DEGREE);
    end
    for (int i = 0; i < DATA_W; i++) begin
      res.mask[i]   = (i < int'(m));
      res.topbit[i] = (i == int'(m) - 1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- src/gf2m_in_if.sv -----
// ----------------------------------------------------------------------------
// gf2m_in_if
// Operand channel: valid/ready handshake carrying the two field elements.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gf2m_in_if;
  logic                        valid;
  logic                        ready;
  logic [gf2m_pkg::DATA_W-1:0] operand_a;
  logic [gf2m_pkg::DATA_W-1:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface

`default_nettype wire

// ----- src/gf2m_out_if.sv -----
// ----------------------------------------------------------------------------
// gf2m_out_if
// Result channel: valid/ready handshake carrying the reduced product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gf2m_out_if;
  logic                        valid;
  logic                        ready;
  logic [gf2m_pkg::DATA_W-1:0] product;

  modport source (output valid, output product, input ready);
  modport sink (input valid, input product, output ready);
endinterface

`default_nettype wire

// ----- src/gf2m_multiplier.sv -----
// ----------------------------------------------------------------------------
// gf2m_multiplier
// GF(2^m) polynomial basis multiplier built as a chain of bit cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  carries operand_a and operand_b; an item is taken when valid and
//          ready are both high. Bits at and above m are ignored.
//   out_if carries the reduced product, one result per item, in order.
//   cfg_we/cfg_idx/cfg_wdata write field_degree (index 0) and
//          reduction_poly_low (index 1); write only while the chain is empty.
// Pipeline: each item moves through the cell registers in order; one cell
//   per operand bit, 32 cells. Throughput: one item per cycle while
//   out_if.ready is high; each cell holds one item and passes it on.
// Stall: when out_if.ready is low the last cell holds its result; cells with
//   empty slots further up still take items until the chain is full, then
//   in_if.ready drops. No item is lost or repeated.
// Reset: synchronous active-low rst_n empties every cell and restores
//   degree 8 with polynomial x^8+x^4+x^3+x+1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gf2m_multiplier_macros.svh"

module gf2m_multiplier (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  gf2m_in_if.sink                              in_if,
  gf2m_out_if.source                           out_if,
  input  wire logic                            cfg_we,
  input  wire logic [gf2m_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [gf2m_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  gf2m_pkg::field_cfg_t field_cfg;
  logic                 valid_c [gf2m_pkg::NUM_CELLS+1];
  logic                 ready_c [gf2m_pkg::NUM_CELLS+1];
  gf2m_pkg::stage_t     data_c  [gf2m_pkg::NUM_CELLS+1];

  // configuration registers
  gf2m_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .field_cfg (field_cfg)
  );

  // head of the chain: masked operands, zero remainder
  assign valid_c[0]     = in_if.valid;
  assign in_if.ready    = ready_c[0];
  assign data_c[0].acc  = '0;
  assign data_c[0].a    = in_if.operand_a & field_cfg.mask;
  assign data_c[0].b    = in_if.operand_b & field_cfg.mask;

  // cell chain, msb of b first
  for (genvar k = 0; k < gf2m_pkg::NUM_CELLS; k++) begin : g_cell
    gf2m_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .field_cfg (field_cfg),
      .valid_i   (valid_c[k]),
      .data_i    (data_c[k]),
      .ready_o   (ready_c[k]),
      .valid_o   (valid_c[k+1]),
      .data_o    (data_c[k+1]),
      .ready_i   (ready_c[k+1])
    );
  end

  // tail of the chain drives the result channel
  assign out_if.valid                     = valid_c[gf2m_pkg::NUM_CELLS];
  assign out_if.product                   = data_c[gf2m_pkg::NUM_CELLS].acc;
  assign ready_c[gf2m_pkg::NUM_CELLS]     = out_if.ready;

  // checks
  `GF2M_ASSERT_NOW(a_product_in_field, out_if.valid,
    (out_if.product & ~field_cfg.mask) == '0, "product has coefficients at or above m")
  `GF2M_ASSERT_NOW(a_ready_when_draining, out_if.ready, in_if.ready,
    "input stalled while the result side drains")
  `GF2M_ASSERT_NEXT(a_item_enters_chain, in_if.valid && in_if.ready, valid_c[1],
    "accepted item missing from first cell")

endmodule

`default_nettype wire

// ----- src/gf2m_cfg.sv -----
// ----------------------------------------------------------------------------
// gf2m_cfg
// Configuration registers; holds the decoded degree masks and the masked
// reduction polynomial for the cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gf2m_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [gf2m_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [gf2m_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output gf2m_pkg::field_cfg_t                 field_cfg
);

  gf2m_pkg::deg_masks_t        masks_r;
  logic [gf2m_pkg::DATA_W-1:0] poly_r;

  // register writes, degree decoded as it is written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      masks_r <= gf2m_pkg::deg_masks(gf2m_pkg::RESET_DEGREE);
      poly_r  <= gf2m_pkg::RESET_POLY;
    end else if (cfg_we) begin
      case (cfg_idx)
        gf2m_pkg::REG_FIELD_DEGREE: begin
          masks_r <= gf2m_pkg::deg_masks(cfg_wdata[gf2m_pkg::DEG_W-1:0]);
        end
        gf2m_pkg::REG_POLY_LOW: begin
          poly_r <= cfg_wdata[gf2m_pkg::DATA_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // coefficients at and above m are dropped
  assign field_cfg.mask   = masks_r.mask;
  assign field_cfg.topbit = masks_r.topbit;
  assign field_cfg.poly   = poly_r & masks_r.mask;

endmodule

`default_nettype wire

// ----- src/gf2m_cell.sv -----
// ----------------------------------------------------------------------------
// gf2m_cell
// One step of the msb-first interleaved multiply: multiplies the running
// remainder by x modulo P, then adds a if the current bit of b is set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gf2m_cell (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire gf2m_pkg::field_cfg_t field_cfg,
  input  wire logic                 valid_i,
  input  wire gf2m_pkg::stage_t     data_i,
  output logic                      ready_o,
  output logic                      valid_o,
  output gf2m_pkg::stage_t          data_o,
  input  wire logic                 ready_i
);

  logic                        valid_r;
  gf2m_pkg::stage_t            data_r;
  gf2m_pkg::stage_t            data_nxt;
  logic                        top;
  logic [gf2m_pkg::DATA_W-1:0] acc_x;

  // stage can take an item when empty or when its item moves on
  assign ready_o = !valid_r || ready_i;

  // acc * x mod P, acc always below degree m
  always_comb begin
    top   = |(data_i.acc & field_cfg.topbit);
    acc_x = {data_i.acc[gf2m_pkg::DATA_W-2:0], 1'b0} & field_cfg.mask;
    if (top) begin
      acc_x = acc_x ^ field_cfg.poly;
    end
    data_nxt.acc = acc_x ^ (data_i.b[gf2m_pkg::DATA_W-1] ? data_i.a : '0);
    data_nxt.a   = data_i.a;
    data_nxt.b   = {data_i.b[gf2m_pkg::DATA_W-2:0], 1'b0};
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

`default_nettype wire
